// ----- sv/wsm_pkg.sv -----
// Shared widths, constants, mode codes and payload types of the wheel speed mixer.
package wsm_pkg;

    localparam int SPEED_WIDTH = 16;
    localparam int FRAC_BITS   = 12;

    // The mixing coefficients are held with this many fraction bits.
    localparam int K_SHIFT = 30;

    localparam int LANES  = 4;
    localparam int EXT_W  = SPEED_WIDTH + 1;
    localparam int SUM_W  = SPEED_WIDTH + 2;
    localparam int MAG_W  = SPEED_WIDTH + 1;
    localparam int PROD_W = SPEED_WIDTH + K_SHIFT + 2;
    localparam int QUO_W  = FRAC_BITS + 1;
    localparam int DIV_W  = SPEED_WIDTH + FRAC_BITS + 2;
    localparam int FIN_W  = (SUM_W > QUO_W + 1) ? SUM_W : QUO_W + 1;

    localparam logic signed [K_SHIFT:0] K_COS30  = 31'sd929887697;
    localparam logic signed [K_SHIFT:0] K_RSQRT2 = 31'sd759250125;

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'sd1 <<< (K_SHIFT - 1));
    localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(64'd1 << FRAC_BITS);
    localparam logic [QUO_W-1:0] ONE_QUO = QUO_W'(64'd1 << FRAC_BITS);

    localparam logic signed [FIN_W-1:0] SAT_HI =
        FIN_W'((64'sd1 <<< (SPEED_WIDTH - 1)) - 64'sd1);
    localparam logic signed [FIN_W-1:0] SAT_LO =
        FIN_W'(-(64'sd1 <<< (SPEED_WIDTH - 1)));

    typedef enum logic [1:0] {
        MODE_DIFF    = 2'd0,
        MODE_OMNI    = 2'd1,
        MODE_MECANUM = 2'd2
    } t_drive_mode;

    typedef struct packed {
        logic signed [SPEED_WIDTH-1:0] vel_x;
        logic signed [SPEED_WIDTH-1:0] vel_y;
        logic signed [SPEED_WIDTH-1:0] turn_rate;
    } t_cmd;

    typedef struct packed {
        logic signed [SPEED_WIDTH-1:0] wheel_front_left;
        logic signed [SPEED_WIDTH-1:0] wheel_front_right;
        logic signed [SPEED_WIDTH-1:0] wheel_back_left;
        logic signed [SPEED_WIDTH-1:0] wheel_back_right;
        logic                          clipped;
    } t_wheels;

endpackage

// ----- sv/wheel_speed_mixer_unit.sv -----
// Top level of the wheel speed mixer: velocity command in, four wheel speeds out.
//
// A command (vel_x, vel_y, turn_rate) is transferred on the i_cmd channel when
// i_cmd_valid is high and o_cmd_stall is low. Its four wheel speeds and the clipped
// flag leave on the o_wheel channel, a transfer happening when o_wheel_valid is high
// and i_wheel_stall is low. Results come out in command order.
// The drive type is written through i_cfg_valid / i_cfg_data; o_cfg_ready is always
// high. Write it only while no command is in flight.
// One command per cycle is taken while o_cmd_stall is low; the depth is set by the
// mecanum normalization, a restoring divider that settles one quotient bit per stage.
// When the receiver stalls while a result is waiting, the whole pipeline holds and
// o_cmd_stall rises in the same cycle; nothing is dropped or repeated.
// Synchronous reset empties the pipeline and selects differential drive.
module wheel_speed_mixer_unit
    import wsm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    output logic       o_cmd_stall,
    input  t_cmd       i_cmd,
    output logic       o_wheel_valid,
    input  logic       i_wheel_stall,
    output t_wheels    o_wheel,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    logic        w_adv;
    t_drive_mode r_drive_mode;

    // Stage 1: captured command, sum and difference for the mecanum mix.
    logic                          r_s1_valid;
    t_drive_mode                   r_s1_mode;
    logic signed [SPEED_WIDTH-1:0] r_s1_x, r_s1_y, r_s1_w;
    logic signed [EXT_W-1:0]       r_s1_dif, r_s1_sum;

    // Stage 2: coefficient products.
    logic                          r_s2_valid;
    t_drive_mode                   r_s2_mode;
    logic signed [SPEED_WIDTH-1:0] r_s2_x, r_s2_y, r_s2_w;
    logic signed [PROD_W-1:0]      r_s2_pxc, r_s2_pyc, r_s2_pdif, r_s2_psum;

    // Stage 3: raw wheel speeds.
    logic                          r_s3_valid;
    t_drive_mode                   r_s3_mode;
    logic signed [SUM_W-1:0]       r_s3_s [LANES];
    logic signed [SUM_W-1:0]       n_s3_s [LANES];

    // Stage 4: sign and magnitude.
    logic                          r_s4_valid;
    t_drive_mode                   r_s4_mode;
    logic [MAG_W-1:0]              r_s4_mag [LANES];
    logic                          r_s4_neg [LANES];

    // Stage 5: largest magnitude, never below one.
    logic                          r_s5_valid;
    t_drive_mode                   r_s5_mode;
    logic [MAG_W-1:0]              r_s5_mag [LANES];
    logic                          r_s5_neg [LANES];
    logic [MAG_W-1:0]              r_s5_m;
    logic [MAG_W-1:0]              n_s5_m;

    // Divider pipeline: position 0 holds the dividend, position p holds p quotient bits.
    logic                          r_dv_valid [0:QUO_W];
    t_drive_mode                   r_dv_mode  [0:QUO_W];
    logic [MAG_W-1:0]              r_dv_m     [0:QUO_W];
    logic [DIV_W-1:0]              r_dv_rem   [0:QUO_W][LANES];
    logic [QUO_W-1:0]              r_dv_quo   [0:QUO_W][LANES];
    logic [MAG_W-1:0]              r_dv_mag   [0:QUO_W][LANES];
    logic                          r_dv_neg   [0:QUO_W][LANES];
    logic [DIV_W-1:0]              n_dv_rem   [0:QUO_W][LANES];
    logic [QUO_W-1:0]              n_dv_quo   [0:QUO_W][LANES];

    // Output register.
    logic                          r_out_valid;
    t_wheels                       r_out;
    t_wheels                       n_out;

    assign w_adv         = !(r_out_valid && i_wheel_stall);
    assign o_cmd_stall   = !w_adv;
    assign o_wheel_valid = r_out_valid;
    assign o_wheel       = r_out;
    assign o_cfg_ready   = 1'b1;

    // Stage 3 arithmetic: round the products to FRAC_BITS and add the turn rate.
    always_comb begin
        logic signed [PROD_W-1:0] xh, yh;
        logic signed [SUM_W-1:0]  x, y, w, o1, o2, a, b;
        xh = PROD_W'(r_s2_x) <<< (K_SHIFT - 1);
        yh = PROD_W'(r_s2_y) <<< (K_SHIFT - 1);
        x  = SUM_W'(r_s2_x);
        y  = SUM_W'(r_s2_y);
        w  = SUM_W'(r_s2_w);
        o1 = SUM_W'((r_s2_pxc + yh + RND_HALF) >>> K_SHIFT) + w;
        o2 = SUM_W'((xh + r_s2_pyc + RND_HALF) >>> K_SHIFT) + w;
        a  = SUM_W'((r_s2_pdif + RND_HALF) >>> K_SHIFT);
        b  = SUM_W'((r_s2_psum + RND_HALF) >>> K_SHIFT);
        for (int i = 0; i < LANES; i++) begin
            n_s3_s[i] = '0;
        end
        unique case (r_s2_mode)
            MODE_DIFF: begin
                n_s3_s[0] = y + w;
                n_s3_s[1] = y - w;
            end
            MODE_OMNI: begin
                n_s3_s[0] = x + w;
                n_s3_s[1] = o1;
                n_s3_s[2] = o2;
            end
            MODE_MECANUM: begin
                n_s3_s[0] = a - w;
                n_s3_s[1] = b + w;
                n_s3_s[2] = b - w;
                n_s3_s[3] = a + w;
            end
            default: begin
                n_s3_s[0] = '0;
            end
        endcase
    end

    // Stage 5: maximum over the four magnitudes and one.
    always_comb begin
        logic [MAG_W-1:0] m01, m23, m;
        m01    = (r_s4_mag[0] > r_s4_mag[1]) ? r_s4_mag[0] : r_s4_mag[1];
        m23    = (r_s4_mag[2] > r_s4_mag[3]) ? r_s4_mag[2] : r_s4_mag[3];
        m      = (m01 > m23) ? m01 : m23;
        n_s5_m = (m > ONE_MAG) ? m : ONE_MAG;
    end

    // Dividend |s| * ONE + m / 2, then one restoring step per position, MSB first.
    always_comb begin
        logic [DIV_W-1:0] dsub;
        logic             ge;
        for (int i = 0; i < LANES; i++) begin
            n_dv_rem[0][i] = (DIV_W'(r_s5_mag[i]) << FRAC_BITS) + DIV_W'(r_s5_m >> 1);
            n_dv_quo[0][i] = '0;
        end
        for (int p = 1; p <= QUO_W; p++) begin
            for (int i = 0; i < LANES; i++) begin
                dsub           = DIV_W'(r_dv_m[p-1]) << (QUO_W - p);
                ge             = r_dv_rem[p-1][i] >= dsub;
                n_dv_rem[p][i] = ge ? (r_dv_rem[p-1][i] - dsub) : r_dv_rem[p-1][i];
                n_dv_quo[p][i] = {r_dv_quo[p-1][i][QUO_W-2:0], ge};
            end
        end
    end

    // Output: pick the normalized or the raw magnitude, restore the sign, saturate.
    always_comb begin
        logic [FIN_W-1:0]              v;
        logic signed [FIN_W-1:0]       sv;
        logic signed [SPEED_WIDTH-1:0] wh [LANES];
        logic                          clip;
        clip = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            if (r_dv_mode[QUO_W] == MODE_MECANUM) begin
                v = FIN_W'(r_dv_quo[QUO_W][i]);
            end else begin
                v = FIN_W'(r_dv_mag[QUO_W][i]);
            end
            sv = r_dv_neg[QUO_W][i] ? -$signed(v) : $signed(v);
            if (sv > SAT_HI) begin
                wh[i] = SPEED_WIDTH'(SAT_HI);
                clip  = 1'b1;
            end else if (sv < SAT_LO) begin
                wh[i] = SPEED_WIDTH'(SAT_LO);
                clip  = 1'b1;
            end else begin
                wh[i] = SPEED_WIDTH'(sv);
            end
        end
        n_out.wheel_front_left  = wh[0];
        n_out.wheel_front_right = wh[1];
        n_out.wheel_back_left   = wh[2];
        n_out.wheel_back_right  = wh[3];
        n_out.clipped           = clip;
    end

    // Control state: drive mode and the valid bit of every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_mode <= MODE_DIFF;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_s3_valid   <= 1'b0;
            r_s4_valid   <= 1'b0;
            r_s5_valid   <= 1'b0;
            for (int p = 0; p <= QUO_W; p++) begin
                r_dv_valid[p] <= 1'b0;
            end
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_drive_mode <= t_drive_mode'(i_cfg_data);
            end
            if (w_adv) begin
                r_s1_valid    <= i_cmd_valid;
                r_s2_valid    <= r_s1_valid;
                r_s3_valid    <= r_s2_valid;
                r_s4_valid    <= r_s3_valid;
                r_s5_valid    <= r_s4_valid;
                r_dv_valid[0] <= r_s5_valid;
                for (int p = 1; p <= QUO_W; p++) begin
                    r_dv_valid[p] <= r_dv_valid[p-1];
                end
                r_out_valid   <= r_dv_valid[QUO_W];
            end
        end
    end

    // Datapath registers; they all move together with the valid bits.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_mode <= r_drive_mode;
            r_s1_x    <= i_cmd.vel_x;
            r_s1_y    <= i_cmd.vel_y;
            r_s1_w    <= i_cmd.turn_rate;
            r_s1_dif  <= EXT_W'(i_cmd.vel_y) - EXT_W'(i_cmd.vel_x);
            r_s1_sum  <= EXT_W'(i_cmd.vel_y) + EXT_W'(i_cmd.vel_x);

            r_s2_mode <= r_s1_mode;
            r_s2_x    <= r_s1_x;
            r_s2_y    <= r_s1_y;
            r_s2_w    <= r_s1_w;
            r_s2_pxc  <= PROD_W'(r_s1_x) * PROD_W'(K_COS30);
            r_s2_pyc  <= PROD_W'(r_s1_y) * PROD_W'(K_COS30);
            r_s2_pdif <= PROD_W'(r_s1_dif) * PROD_W'(K_RSQRT2);
            r_s2_psum <= PROD_W'(r_s1_sum) * PROD_W'(K_RSQRT2);

            r_s3_mode <= r_s2_mode;
            r_s4_mode <= r_s3_mode;
            r_s5_mode <= r_s4_mode;
            r_s5_m    <= n_s5_m;
            for (int i = 0; i < LANES; i++) begin
                r_s3_s[i]   <= n_s3_s[i];
                r_s4_neg[i] <= r_s3_s[i][SUM_W-1];
                r_s4_mag[i] <= MAG_W'(r_s3_s[i][SUM_W-1] ? -r_s3_s[i] : r_s3_s[i]);
                r_s5_neg[i] <= r_s4_neg[i];
                r_s5_mag[i] <= r_s4_mag[i];
            end

            r_dv_mode[0] <= r_s5_mode;
            r_dv_m[0]    <= r_s5_m;
            for (int i = 0; i < LANES; i++) begin
                r_dv_rem[0][i] <= n_dv_rem[0][i];
                r_dv_quo[0][i] <= n_dv_quo[0][i];
                r_dv_mag[0][i] <= r_s5_mag[i];
                r_dv_neg[0][i] <= r_s5_neg[i];
            end
            for (int p = 1; p <= QUO_W; p++) begin
                r_dv_mode[p] <= r_dv_mode[p-1];
                r_dv_m[p]    <= r_dv_m[p-1];
                for (int i = 0; i < LANES; i++) begin
                    r_dv_rem[p][i] <= n_dv_rem[p][i];
                    r_dv_quo[p][i] <= n_dv_quo[p][i];
                    r_dv_mag[p][i] <= r_dv_mag[p-1][i];
                    r_dv_neg[p][i] <= r_dv_neg[p-1][i];
                end
            end

            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    // After the last step every remainder is below the divisor.
    a_div_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_valid[QUO_W] |->
            (r_dv_rem[QUO_W][0] < DIV_W'(r_dv_m[QUO_W])) &&
            (r_dv_rem[QUO_W][1] < DIV_W'(r_dv_m[QUO_W])) &&
            (r_dv_rem[QUO_W][2] < DIV_W'(r_dv_m[QUO_W])) &&
            (r_dv_rem[QUO_W][3] < DIV_W'(r_dv_m[QUO_W])))
        else $error("divider remainder not below divisor");

    // Normalized mecanum speeds never exceed one.
    a_mecanum_norm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_valid[QUO_W] && (r_dv_mode[QUO_W] == MODE_MECANUM) |->
            (r_dv_quo[QUO_W][0] <= ONE_QUO) && (r_dv_quo[QUO_W][1] <= ONE_QUO) &&
            (r_dv_quo[QUO_W][2] <= ONE_QUO) && (r_dv_quo[QUO_W][3] <= ONE_QUO))
        else $error("normalized wheel speed above one");

    // A finished item reaches the output register whenever the pipeline advances.
    a_result_moves_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_valid[QUO_W] && !o_cmd_stall |=> o_wheel_valid)
        else $error("finished item lost before the output register");
`endif

endmodule

// ----- tb/tb_wheel_speed_mixer_unit.sv -----
// Self-checking testbench of the wheel speed mixer over all drive modes.
`timescale 1ns / 1ps

module tb_wheel_speed_mixer_unit
    import wsm_pkg::*;
();

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int PIPE_LATENCY = FRAC_BITS + 7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_CMDS = 118;

    localparam longint ONE_SPEED = longint'(1) <<< FRAC_BITS;
    localparam longint Q30_COS30 = 929887697;
    localparam longint Q30_HALF = 536870912;
    localparam longint Q30_RSQRT2 = 759250125;
    localparam longint SPEED_HI = (longint'(1) <<< (SPEED_WIDTH - 1)) - 1;
    localparam longint SPEED_LO = -(longint'(1) <<< (SPEED_WIDTH - 1));
    localparam logic signed [SPEED_WIDTH-1:0] SPEED_MAX = {1'b0, {(SPEED_WIDTH-1){1'b1}}};
    localparam logic signed [SPEED_WIDTH-1:0] SPEED_MIN = {1'b1, {(SPEED_WIDTH-1){1'b0}}};

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cmd_valid = 1'b0;
    logic       o_cmd_stall;
    t_cmd       i_cmd = '0;
    logic       o_wheel_valid;
    logic       i_wheel_stall = 1'b0;
    t_wheels    o_wheel;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_data = 2'd0;

    t_cmd       cmd_queue[$];
    t_wheels    wheels_expected[$];
    logic [1:0] model_mode = MODE_DIFF;
    bit         cmd_taken = 1'b0;
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         error_count = 0;
    int         cycle_count = 0;

    wheel_speed_mixer_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (i_cmd_valid),
        .o_cmd_stall   (o_cmd_stall),
        .i_cmd         (i_cmd),
        .o_wheel_valid (o_wheel_valid),
        .i_wheel_stall (i_wheel_stall),
        .o_wheel       (o_wheel),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Rounds a sum with 30 extra fraction bits, half toward plus infinity.
    function automatic longint round_frac(longint p);
        return (p + (longint'(1) <<< 29)) >>> 30;
    endfunction

    function automatic t_wheels mix_wheels(t_cmd c, logic [1:0] mode);
        longint x, y, w, a, b, peak, mag, q;
        longint lane[4];
        logic   clip;
        t_wheels r;
        int     i;
        x = longint'($signed(c.vel_x));
        y = longint'($signed(c.vel_y));
        w = longint'($signed(c.turn_rate));
        for (i = 0; i < 4; i++) lane[i] = 0;
        clip = 1'b0;
        case (mode)
            MODE_DIFF: begin
                lane[0] = y + w;
                lane[1] = y - w;
            end
            MODE_OMNI: begin
                lane[0] = x + w;
                lane[1] = round_frac(x * Q30_COS30 + y * Q30_HALF) + w;
                lane[2] = round_frac(x * Q30_HALF + y * Q30_COS30) + w;
            end
            MODE_MECANUM: begin
                a = round_frac((y - x) * Q30_RSQRT2);
                b = round_frac((y + x) * Q30_RSQRT2);
                lane[0] = a - w;
                lane[1] = b + w;
                lane[2] = b - w;
                lane[3] = a + w;
                peak = ONE_SPEED;
                for (i = 0; i < 4; i++) begin
                    mag = (lane[i] < 0) ? -lane[i] : lane[i];
                    if (mag > peak) peak = mag;
                end
                // Scale all wheels down together so the fastest one runs at full speed.
                if (peak > ONE_SPEED) begin
                    for (i = 0; i < 4; i++) begin
                        mag = (lane[i] < 0) ? -lane[i] : lane[i];
                        q = (mag * ONE_SPEED + peak / 2) / peak;
                        lane[i] = (lane[i] < 0) ? -q : q;
                    end
                end
            end
            default: ;
        endcase
        for (i = 0; i < 4; i++) begin
            if (lane[i] > SPEED_HI) begin
                lane[i] = SPEED_HI;
                clip = 1'b1;
            end else if (lane[i] < SPEED_LO) begin
                lane[i] = SPEED_LO;
                clip = 1'b1;
            end
        end
        r.wheel_front_left  = SPEED_WIDTH'(lane[0]);
        r.wheel_front_right = SPEED_WIDTH'(lane[1]);
        r.wheel_back_left   = SPEED_WIDTH'(lane[2]);
        r.wheel_back_right  = SPEED_WIDTH'(lane[3]);
        r.clipped           = clip;
        return r;
    endfunction

    function automatic logic signed [SPEED_WIDTH-1:0] rand_speed();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return SPEED_MAX;
                    1: return SPEED_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            // Around unit speed, where mecanum scaling switches on and off.
            1, 2, 3: return SPEED_WIDTH'(longint'($urandom_range(0, 2 * ONE_SPEED)) - ONE_SPEED);
            4, 5: return SPEED_WIDTH'(longint'($urandom_range(0, 4 * ONE_SPEED)) - 2 * ONE_SPEED);
            default: return SPEED_WIDTH'($urandom);
        endcase
    endfunction

    task automatic queue_cmd(logic signed [SPEED_WIDTH-1:0] x, logic signed [SPEED_WIDTH-1:0] y,
                             logic signed [SPEED_WIDTH-1:0] w);
        t_cmd c;
        c.vel_x = x;
        c.vel_y = y;
        c.turn_rate = w;
        cmd_queue.push_back(c);
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || i_cmd_valid || wheels_expected.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_drive_mode(logic [1:0] mode);
        wait_drained();
        repeat (PIPE_LATENCY) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic compare_field(string name, longint want, longint got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Command driver: a new transfer is offered only once the current one has been taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_cmd_valid <= 1'b0;
            i_wheel_stall <= 1'b0;
        end else begin
            i_wheel_stall <= ($urandom_range(0, 99) < stall_pct);
            if (!i_cmd_valid || cmd_taken) begin
                if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    i_cmd <= cmd_queue.pop_front();
                    i_cmd_valid <= 1'b1;
                end else begin
                    i_cmd_valid <= 1'b0;
                end
            end
            cmd_taken = 1'b0;
        end
    end

    always @(posedge i_clk) begin : wheel_monitor
        t_wheels want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) model_mode = i_cfg_data;
            if (i_cmd_valid && !o_cmd_stall) begin
                wheels_expected.push_back(mix_wheels(i_cmd, model_mode));
                cmd_taken = 1'b1;
            end
            if (o_wheel_valid && !i_wheel_stall) begin
                if (wheels_expected.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected wheel transfer, expected none, got %h", $time,
                             o_wheel);
                end else begin
                    want = wheels_expected.pop_front();
                    compare_field("wheel_front_left", $signed(want.wheel_front_left),
                                  $signed(o_wheel.wheel_front_left));
                    compare_field("wheel_front_right", $signed(want.wheel_front_right),
                                  $signed(o_wheel.wheel_front_right));
                    compare_field("wheel_back_left", $signed(want.wheel_back_left),
                                  $signed(o_wheel.wheel_back_left));
                    compare_field("wheel_back_right", $signed(want.wheel_back_right),
                                  $signed(o_wheel.wheel_back_right));
                    compare_field("clipped", want.clipped, o_wheel.clipped);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int m, p, n;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Corner commands in every drive mode, including the undefined one.
        for (m = 0; m < 4; m++) begin
            set_drive_mode(2'(m));
            queue_cmd('0, '0, '0);
            queue_cmd(SPEED_MAX, SPEED_MAX, SPEED_MAX);
            queue_cmd(SPEED_MIN, SPEED_MIN, SPEED_MIN);
            queue_cmd(SPEED_MAX, SPEED_MIN, SPEED_MAX);
            queue_cmd(SPEED_MIN, SPEED_MAX, SPEED_MIN);
            queue_cmd(SPEED_WIDTH'(ONE_SPEED), SPEED_WIDTH'(ONE_SPEED), SPEED_WIDTH'(-ONE_SPEED));
        end

        for (p = 0; p < 16; p++) begin
            wait_drained();
            case (p / 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 46; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 46; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            set_drive_mode((p % 4 == 3) ? MODE_UNUSED : 2'(p % 4));
            for (n = 0; n < PHASE_CMDS; n++) begin
                // Halfway through one phase the sender holds back until the pipe is empty.
                if (p == 6 && n == PHASE_CMDS / 2) wait_drained();
                queue_cmd(rand_speed(), rand_speed(), rand_speed());
            end
        end

        wait_drained();
        repeat (PIPE_LATENCY + 5) @(posedge i_clk);
        if (error_count == 0 && wheels_expected.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/wsm_pkg.sv
sv/wheel_speed_mixer_unit.sv
tb/tb_wheel_speed_mixer_unit.sv
